FILE: rtl/crng_pkg.sv
package crng_pkg;

    localparam int WORD_W = 31;

    typedef logic [WORD_W-1:0] word_t;

    // Generator constants. Each modulus sits just below 2^31, so 2^31 folds
    // back into the residue as a small offset.
    localparam word_t       MOD_ONE       = 31'd2147483563;
    localparam word_t       MOD_TWO       = 31'd2147483399;
    localparam logic [15:0] MUL_ONE       = 16'd40014;
    localparam logic [15:0] MUL_TWO       = 16'd40692;
    localparam logic [7:0]  OFF_ONE       = 8'd85;
    localparam logic [7:0]  OFF_TWO       = 8'd249;
    localparam word_t       MOD_ONE_LESS  = 31'd2147483562;
    localparam word_t       VALUE_MAX     = 31'd2147483305;
    localparam word_t       GEN_ONE_RESET = 31'd1;
    localparam word_t       GEN_TWO_RESET = 31'd123456789;

    // Request actions.
    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_RESEED = 1'b1;

    // Generator select for the modular multiply unit.
    localparam logic GEN_ONE = 1'b0;
    localparam logic GEN_TWO = 1'b1;

endpackage

FILE: rtl/crng_req_if.sv
interface crng_req_if;

    logic                 valid;
    logic                 ready;
    logic                 action;
    crng_pkg::word_t      seed;

    modport source (output valid, output action, output seed, input ready);
    modport sink   (input valid, input action, input seed, output ready);

endinterface

FILE: rtl/crng_rsp_if.sv
interface crng_rsp_if;

    logic                 valid;
    logic                 ready;
    crng_pkg::word_t      value;
    logic                 clamped;

    modport source (output valid, output value, output clamped, input ready);
    modport sink   (input valid, input value, input clamped, output ready);

endinterface

FILE: rtl/crng_ram.sv
module crng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/crng_modmul.sv
module crng_modmul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            gen_sel,
    input  crng_pkg::word_t operand,
    output crng_pkg::word_t result
);

    logic [15:0]     mul;
    logic [7:0]      off;
    crng_pkg::word_t modulus;

    logic [46:0]     prod_reg;
    logic            stage_reg;
    crng_pkg::word_t result_reg;

    logic [15:0]     hi;
    logic [31:0]     folded;
    crng_pkg::word_t reduced;

    always_comb
    begin
        unique case (gen_sel)
            crng_pkg::GEN_ONE:
            begin
                mul     = crng_pkg::MUL_ONE;
                off     = crng_pkg::OFF_ONE;
                modulus = crng_pkg::MOD_ONE;
            end
            default:
            begin
                mul     = crng_pkg::MUL_TWO;
                off     = crng_pkg::OFF_TWO;
                modulus = crng_pkg::MOD_TWO;
            end
        endcase
    end

    // The product is hi * 2^31 + lo, and 2^31 equals the offset modulo the
    // modulus. The folded sum stays below twice the modulus.
    always_comb
    begin
        hi      = prod_reg[46:31];
        folded  = {1'b0, prod_reg[30:0]} + (32'(hi) * 32'(off));
        reduced = (folded >= {1'b0, modulus}) ? 31'(folded - {1'b0, modulus})
                                               : folded[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= 47'(operand) * 47'(mul);
        end
        if (stage_reg)
        begin
            result_reg <= reduced;
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/crng_slot.sv
module crng_slot #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     start,
    input  crng_pkg::word_t          x,
    output logic [$clog2(DEPTH)-1:0] slot
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int Q_W   = IDX_W + 1;
    localparam longint unsigned SLOT_DIV =
        64'd1 + 64'(crng_pkg::MOD_ONE_LESS) / 64'(DEPTH);
    // With this shift the estimate x * RECIP >> RECIP_SHIFT is the true
    // quotient or one below it, for every 31-bit x.
    localparam int RECIP_SHIFT = 38;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / SLOT_DIV;
    localparam int PROD_W = RECIP_SHIFT + Q_W;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q0_reg;
    crng_pkg::word_t   x_reg;

    logic [31:0]       rem;
    logic [Q_W-1:0]    q;

    assign prod = PROD_W'(x) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q0_reg <= prod[RECIP_SHIFT +: Q_W];
            x_reg  <= x;
        end
    end

    always_comb
    begin
        rem  = {1'b0, x_reg} - 32'(32'(q0_reg) * 32'(SLOT_DIV));
        q    = (rem >= 32'(SLOT_DIV)) ? q0_reg + Q_W'(1) : q0_reg;
        slot = (q > Q_W'(DEPTH - 1)) ? IDX_W'(DEPTH - 1) : q[IDX_W-1:0];
    end

endmodule

FILE: rtl/combined_lcg_shuffle_rng.sv
// Uniform random number generator: two multiplicative congruential generators
// (40014 mod 2147483563 and 40692 mod 2147483399) combined through a shuffle
// table of TABLE_DEPTH entries held in a one-port-read, one-port-write RAM.
// Each request transaction yields exactly one response transaction carrying
// a numerator over 2147483563 in the range 1..2147483305 and a flag that is
// set when the value was saturated at that upper limit. A draw occupies the
// block from acceptance to the next acceptance in order: it is accepted, both
// modular multiplies and the slot estimate start, they finish and the table
// is read, and the result is combined and written back. A reseed first runs
// TABLE_DEPTH+8 warm-up steps of generator one, each through its two-stage
// multiply unit, and then draws as above. The commit cycle waits while an
// earlier response is still held. Out of reset the generators hold 1 and
// 123456789 and the table reads as zeros, so a draw before any reseed is well
// defined.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    crng_req_if.sink    req,
    crng_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 8);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_WARM_MUL    = 3'd1;
    localparam logic [2:0] ST_WARM_WAIT   = 3'd2;
    localparam logic [2:0] ST_WARM_COMMIT = 3'd3;
    localparam logic [2:0] ST_DRAW_MUL    = 3'd4;
    localparam logic [2:0] ST_DRAW_WAIT   = 3'd5;
    localparam logic [2:0] ST_DRAW_COMMIT = 3'd6;

    logic [2:0]             state_reg, state_next;
    crng_pkg::word_t        gen_one_reg, gen_one_next;
    crng_pkg::word_t        gen_two_reg, gen_two_next;
    crng_pkg::word_t        last_out_reg, last_out_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       slot_reg;
    crng_pkg::word_t        out_value_reg;
    logic                   out_clamped_reg;

    logic                   mm1_start, mm2_start;
    crng_pkg::word_t        mm1_operand;
    crng_pkg::word_t        mm1_result, mm2_result;
    logic [IDX_W-1:0]       slot;
    logic                   slot_start;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    crng_pkg::word_t        ram_rd_data;
    logic                   ram_rd_en;

    logic                   commit;
    crng_pkg::word_t        entry;
    crng_pkg::word_t        mixed;
    crng_pkg::word_t        seed_fixed;

    crng_modmul u_mm_one (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm1_start),
        .gen_sel (crng_pkg::GEN_ONE),
        .operand (mm1_operand),
        .result  (mm1_result)
    );

    crng_modmul u_mm_two (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm2_start),
        .gen_sel (crng_pkg::GEN_TWO),
        .operand (gen_two_reg),
        .result  (mm2_result)
    );

    crng_slot #(
        .DEPTH (TABLE_DEPTH)
    ) u_slot (
        .clk   (clk),
        .start (slot_start),
        .x     (last_out_reg),
        .slot  (slot)
    );

    crng_ram #(
        .WIDTH (crng_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (mm1_result),
        .rd_en   (ram_rd_en),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.value   = out_value_reg;
    assign rsp.clamped = out_clamped_reg;

    assign commit     = (state_reg == ST_DRAW_COMMIT) && (!out_valid_reg || rsp.ready);
    assign seed_fixed = (req.seed == '0) ? crng_pkg::GEN_ONE_RESET : req.seed;

    // Entries never written since reset read as zero.
    assign entry = valid_reg[slot_reg] ? ram_rd_data : '0;
    // The true difference always fits in 31 bits, so wrapping arithmetic works.
    assign mixed = (entry > mm2_result) ? entry - mm2_result
                                        : entry - mm2_result + crng_pkg::MOD_ONE_LESS;

    always_comb
    begin
        mm1_start   = 1'b0;
        mm2_start   = 1'b0;
        mm1_operand = gen_one_reg;
        slot_start  = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;

        state_next     = state_reg;
        gen_one_next   = gen_one_reg;
        gen_two_next   = gen_two_reg;
        last_out_next  = last_out_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.action == crng_pkg::ACT_RESEED)
                    begin
                        gen_one_next = seed_fixed;
                        gen_two_next = seed_fixed;
                        count_next   = CNT_W'(TABLE_DEPTH + 7);
                        state_next   = ST_WARM_MUL;
                    end
                    else
                    begin
                        state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_WARM_MUL:
            begin
                mm1_start  = 1'b1;
                state_next = ST_WARM_WAIT;
            end
            ST_WARM_WAIT:
            begin
                state_next = ST_WARM_COMMIT;
            end
            ST_WARM_COMMIT:
            begin
                gen_one_next = mm1_result;
                if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = count_reg[IDX_W-1:0];
                    valid_next[count_reg[IDX_W-1:0]] = 1'b1;
                end
                if (count_reg == '0)
                begin
                    last_out_next = mm1_result;
                    state_next    = ST_DRAW_MUL;
                end
                else
                begin
                    // Chain the next warm-up step straight from the result.
                    mm1_start   = 1'b1;
                    mm1_operand = mm1_result;
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = ST_WARM_WAIT;
                end
            end
            ST_DRAW_MUL:
            begin
                mm1_start  = 1'b1;
                mm2_start  = 1'b1;
                slot_start = 1'b1;
                state_next = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_DRAW_COMMIT;
            end
            ST_DRAW_COMMIT:
            begin
                if (commit)
                begin
                    gen_one_next   = mm1_result;
                    gen_two_next   = mm2_result;
                    last_out_next  = mixed;
                    ram_wr_en      = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_one_reg   <= crng_pkg::GEN_ONE_RESET;
            gen_two_reg   <= crng_pkg::GEN_TWO_RESET;
            last_out_reg  <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_one_reg   <= gen_one_next;
            gen_two_reg   <= gen_two_next;
            last_out_reg  <= last_out_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DRAW_WAIT)
        begin
            slot_reg <= slot;
        end
        if (commit)
        begin
            out_value_reg   <= (mixed > crng_pkg::VALUE_MAX) ? crng_pkg::VALUE_MAX : mixed;
            out_clamped_reg <= (mixed > crng_pkg::VALUE_MAX);
        end
    end

endmodule

FILE: bench/combined_lcg_shuffle_rng_tb.sv
module combined_lcg_shuffle_rng_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 32;
    localparam int RANDOM_ITEMS = 1126;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;

    // Arithmetic constants kept apart from the package so that a wrong
    // package constant shows up as a mismatch.
    localparam longint unsigned MODULUS_A = 64'd2147483563;
    localparam longint unsigned MODULUS_B = 64'd2147483399;
    localparam longint unsigned FACTOR_A = 64'd40014;
    localparam longint unsigned FACTOR_B = 64'd40692;
    localparam longint WRAP_ADD = 64'd2147483562;
    localparam longint unsigned SLOT_SPAN = 64'd1 + (MODULUS_A - 64'd1) / TABLE_DEPTH;
    localparam crng_pkg::word_t SATURATE_AT = 31'd2147483305;
    localparam crng_pkg::word_t SEED_ONES = 31'h7FFF_FFFF;

    typedef struct packed {
        crng_pkg::word_t value;
        logic            clamped;
    } draw_t;

    logic clk;
    logic rst_n;

    crng_req_if req_ch ();
    crng_rsp_if rsp_ch ();

    combined_lcg_shuffle_rng #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Shadow copy of the generator state.
    crng_pkg::word_t gen_a;
    crng_pkg::word_t gen_b;
    crng_pkg::word_t prev_draw;
    crng_pkg::word_t shuffle [TABLE_DEPTH];

    draw_t pending_draws [$];

    int errors;
    int burst_left;
    int n_sent;
    int n_reseeds;
    int n_checked;
    int n_saturated;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic crng_pkg::word_t lcg_step(crng_pkg::word_t state,
                                                 longint unsigned mul,
                                                 longint unsigned modulus);
        longint unsigned prod;
        prod = state * mul;
        return crng_pkg::word_t'(prod % modulus);
    endfunction

    function automatic void predict_draw(logic act, crng_pkg::word_t seed_val);
        crng_pkg::word_t start;
        longint unsigned slot;
        longint diff;
        draw_t result;
        if (act == crng_pkg::ACT_RESEED)
        begin
            start = (seed_val == '0) ? crng_pkg::word_t'(1) : seed_val;
            gen_a = start;
            gen_b = start;
            for (int n = TABLE_DEPTH + 7; n >= 0; n--)
            begin
                gen_a = lcg_step(gen_a, FACTOR_A, MODULUS_A);
                if (n < TABLE_DEPTH)
                    shuffle[n] = gen_a;
            end
            prev_draw = shuffle[0];
        end
        gen_a = lcg_step(gen_a, FACTOR_A, MODULUS_A);
        gen_b = lcg_step(gen_b, FACTOR_B, MODULUS_B);
        slot = prev_draw / SLOT_SPAN;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        diff = longint'(shuffle[slot]) - longint'(gen_b);
        if (diff < 1)
            diff += WRAP_ADD;
        prev_draw = crng_pkg::word_t'(diff);
        shuffle[slot] = gen_a;
        result.clamped = (prev_draw > SATURATE_AT);
        result.value = result.clamped ? SATURATE_AT : prev_draw;
        pending_draws.push_back(result);
    endfunction

    // Entered and left just after a falling edge. Valid stays high across a
    // burst and drops only for the gap in front of the next burst.
    task automatic send_request(input logic act, input crng_pkg::word_t seed_val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_ch.valid = 1'b1;
        req_ch.action = act;
        req_ch.seed = seed_val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_draw(act, seed_val);
        n_sent++;
        if (act == crng_pkg::ACT_RESEED)
            n_reseeds++;
        @(negedge clk);
    endtask

    function automatic crng_pkg::word_t edge_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return crng_pkg::word_t'(1);
            2: return SEED_ONES;
            3: return crng_pkg::word_t'(MODULUS_A);
            4: return crng_pkg::word_t'(MODULUS_B);
            5: return crng_pkg::word_t'(MODULUS_A - 1);
            6: return crng_pkg::word_t'(MODULUS_B + 1);
            7: return crng_pkg::word_t'(MODULUS_A + $urandom_range(1, 84));
            8: return crng_pkg::word_t'($urandom_range(1, 255));
            default: return crng_pkg::word_t'(MODULUS_B - $urandom_range(1, 255));
        endcase
    endfunction

    task automatic test_draw_from_reset();
        send_request(crng_pkg::ACT_DRAW, '0);
        send_request(crng_pkg::ACT_DRAW, SEED_ONES);
        send_request(crng_pkg::ACT_DRAW, crng_pkg::word_t'($urandom));
        send_request(crng_pkg::ACT_DRAW, crng_pkg::word_t'($urandom));
    endtask

    task automatic test_seed_edges();
        crng_pkg::word_t seeds [7];
        seeds = '{'0, crng_pkg::word_t'(1), SEED_ONES,
                  crng_pkg::word_t'(MODULUS_A - 1), crng_pkg::word_t'(MODULUS_A + 1),
                  crng_pkg::word_t'(MODULUS_B - 1), crng_pkg::word_t'(MODULUS_B + 1)};
        foreach (seeds[i])
        begin
            send_request(crng_pkg::ACT_RESEED, seeds[i]);
            send_request(crng_pkg::ACT_DRAW, crng_pkg::word_t'($urandom));
        end
    endtask

    // A seed equal to a modulus pins that generator at zero for good.
    task automatic test_stuck_generators();
        send_request(crng_pkg::ACT_RESEED, crng_pkg::word_t'(MODULUS_A));
        send_request(crng_pkg::ACT_DRAW, SEED_ONES);
        send_request(crng_pkg::ACT_DRAW, '0);
        send_request(crng_pkg::ACT_RESEED, crng_pkg::word_t'(MODULUS_B));
        send_request(crng_pkg::ACT_DRAW, SEED_ONES);
        send_request(crng_pkg::ACT_DRAW, '0);
    endtask

    // Mostly long runs of draws, now and then broken by a reseed.
    task automatic test_random_stream(input int count);
        crng_pkg::word_t seed_val;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                seed_val = ($urandom_range(0, 3) == 0) ? edge_seed()
                                                       : crng_pkg::word_t'($urandom);
                send_request(crng_pkg::ACT_RESEED, seed_val);
            end
            else
            begin
                send_request(crng_pkg::ACT_DRAW, crng_pkg::word_t'($urandom));
            end
        end
    endtask

    // The receiver switches between always ready, coin flips, bursts of
    // long stalls and a fixed one-in-three stall.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int stall_left;
        int phase;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        phase = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase = (phase + 1) % 3;
            case (mode)
                0: rsp_ch.ready = 1'b1;
                1: rsp_ch.ready = 1'($urandom_range(0, 1));
                2:
                begin
                    if (stall_left > 0)
                    begin
                        rsp_ch.ready = 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        rsp_ch.ready = 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 20);
                    end
                end
                default: rsp_ch.ready = (phase != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        draw_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, got value %0d clamped %0b",
                         $time, rsp_ch.value, rsp_ch.clamped);
                errors++;
            end
            else
            begin
                want = pending_draws.pop_front();
                n_checked++;
                if (rsp_ch.clamped === 1'b1)
                    n_saturated++;
                if (rsp_ch.value !== want.value)
                begin
                    $display("%0t: value mismatch: expected %0d, got %0d",
                             $time, want.value, rsp_ch.value);
                    errors++;
                end
                if (rsp_ch.clamped !== want.clamped)
                begin
                    $display("%0t: clamped mismatch: expected %0b, got %0b",
                             $time, want.clamped, rsp_ch.clamped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n)
            quiet = 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet, pending_draws.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        burst_left = 0;
        n_sent = 0;
        n_reseeds = 0;
        n_checked = 0;
        n_saturated = 0;
        gen_a = crng_pkg::word_t'(1);
        gen_b = crng_pkg::word_t'(123456789);
        prev_draw = '0;
        foreach (shuffle[i])
            shuffle[i] = '0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = crng_pkg::ACT_DRAW;
        req_ch.seed = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_draw_from_reset();
        test_seed_edges();
        test_stuck_generators();
        test_random_stream(RANDOM_ITEMS);
        req_ch.valid = 1'b0;

        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests including %0d reseeds; %0d results checked",
                 n_sent, n_reseeds, n_checked);
        $display("saturated results seen: %0d, mismatches: %0d", n_saturated, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
